// File: hdl/verc_pkg.sv
// ----------------------------------------------------------------------------
// verc_pkg: shared types, constants and helpers of the edge clipper
// Q16.16 coordinate formats, transaction structs, status and register codes,
// and the saturation helpers used by the back section.
// ----------------------------------------------------------------------------
package verc_pkg;

  // number formats
  localparam int COORD_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int DIV_W       = COORD_W + 1;
  localparam int DIV_NUM_W   = DIV_W + FRAC_BITS;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int MAP_W       = 31;
  localparam int CFG_IDX_W   = 1;

  // queue depths
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_Q_DEPTH     = 2;

  localparam logic [MAP_W-1:0] MAP_SIZE_RESET = MAP_W'(67108864);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_HORIZONTAL = 2'd1;
  localparam logic [1:0] STATUS_BOTH_INF   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_site_x;
    logic signed [COORD_W-1:0] left_site_y;
    logic signed [COORD_W-1:0] right_site_x;
    logic signed [COORD_W-1:0] right_site_y;
    logic signed [COORD_W-1:0] first_end_x;
    logic signed [COORD_W-1:0] first_end_y;
    logic signed [COORD_W-1:0] second_end_x;
    logic signed [COORD_W-1:0] second_end_y;
    logic                      first_end_infinite;
    logic                      second_end_infinite;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] clipped_first_x;
    logic signed [COORD_W-1:0] clipped_first_y;
    logic signed [COORD_W-1:0] clipped_second_x;
    logic signed [COORD_W-1:0] clipped_second_y;
    logic                      first_was_cut;
    logic                      second_was_cut;
    logic [1:0]                status;
  } out_t;

  // per-edge context carried to the end of the back section
  typedef struct packed {
    logic [1:0]                status;
    logic                      ib;
    logic                      ie;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } ctx_t;

  // classified edge held in the queue between front and back
  typedef struct packed {
    ctx_t             ctx;
    logic [DIV_W-1:0] dx_mag;
    logic [DIV_W-1:0] dy_mag;
    logic             slope_neg;
  } entry_t;

  // saturated magnitude of a signed value given as sign, overflow and magnitude
  function automatic logic [COORD_W-1:0] sat_mag(input logic neg, input logic ovf,
                                                 input logic [PROD_W-1:0] m);
    logic [PROD_W-1:0] lim;
    lim = neg ? (PROD_W'(1) << (COORD_W - 1)) : ((PROD_W'(1) << (COORD_W - 1)) - PROD_W'(1));
    if (ovf || (m > lim)) return lim[COORD_W-1:0];
    return m[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_fit(input logic neg, input logic ovf,
                                                        input logic [PROD_W-1:0] m);
    logic [COORD_W-1:0] mg;
    mg = sat_mag(neg, ovf, m);
    return neg ? $signed(COORD_W'(0) - mg) : $signed(mg);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input logic signed [COORD_W:0] v);
    if (v > $signed({COORD_MAX[COORD_W-1], COORD_MAX})) return COORD_MAX;
    if (v < $signed({COORD_MIN[COORD_W-1], COORD_MIN})) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] abs_coord(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
  endfunction

  function automatic logic [DIV_W-1:0] abs_wide(input logic signed [COORD_W:0] v);
    return v[COORD_W] ? DIV_W'(-v) : DIV_W'(v);
  endfunction

endpackage

// File: hdl/verc_fifo.sv
// ----------------------------------------------------------------------------
// verc_fifo: small register queue
// First-word-fall-through queue with registered count; full and empty come
// straight from state.
// ----------------------------------------------------------------------------
module verc_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hdl/verc_div.sv
// ----------------------------------------------------------------------------
// verc_div: pipelined restoring divider
// Computes (num << FRAC_BITS) / den one quotient bit per stage, with a sticky
// flag for quotient bits beyond the kept width; a tag rides along.
// ----------------------------------------------------------------------------
module verc_div #(
  parameter int TAG_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic [verc_pkg::DIV_W-1:0] in_num,
  input  logic [verc_pkg::DIV_W-1:0] in_den,
  input  logic [TAG_W-1:0]           in_tag,
  output logic                       out_valid,
  output logic [verc_pkg::DIV_W-1:0] out_q,
  output logic                       out_ovf,
  output logic [TAG_W-1:0]           out_tag
);

  localparam int DW = verc_pkg::DIV_W;
  localparam int NW = verc_pkg::DIV_NUM_W;
  localparam int FB = verc_pkg::FRAC_BITS;

  logic             v_r   [NW+1];
  logic [NW-1:0]    n_r   [NW+1];
  logic [DW-1:0]    d_r   [NW+1];
  logic [DW-1:0]    rem_r [NW+1];
  logic [DW-1:0]    q_r   [NW+1];
  logic             ovf_r [NW+1];
  logic [TAG_W-1:0] tag_r [NW+1];

  // operand capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0]   <= in_valid;
      n_r[0]   <= NW'(in_num) << FB;
      d_r[0]   <= in_den;
      rem_r[0] <= '0;
      q_r[0]   <= '0;
      ovf_r[0] <= 1'b0;
      tag_r[0] <= in_tag;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= NW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem_r[k-1], n_r[k-1][NW-k]};
    assign diff  = trial - {1'b0, d_r[k-1]};
    assign ge    = (trial >= {1'b0, d_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k]   <= v_r[k-1];
        n_r[k]   <= n_r[k-1];
        d_r[k]   <= d_r[k-1];
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q_r[k]   <= {q_r[k-1][DW-2:0], ge};
        ovf_r[k] <= ovf_r[k-1] | q_r[k-1][DW-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NW];
  assign out_q     = q_r[NW];
  assign out_ovf   = ovf_r[NW];
  assign out_tag   = tag_r[NW];

endmodule

// File: hdl/verc_front.sv
// ----------------------------------------------------------------------------
// verc_front: edge intake and classification
// Forms the site differences, the slope sign and the status code of each
// edge and queues the result for the back section.
// ----------------------------------------------------------------------------
module verc_front #(
  parameter int QUEUE_DEPTH = verc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  verc_pkg::in_t    in_data,
  output verc_pkg::entry_t head,
  output logic             head_empty,
  input  logic             head_pop
);

  localparam int CW = verc_pkg::COORD_W;
  localparam int DW = verc_pkg::DIV_W;

  logic signed [CW:0]        lx, ly, rx, ry;
  logic signed [CW:0]        dx, dy;
  logic [DW-1:0]             dx_neg_mag, dy_neg_mag;
  verc_pkg::entry_t          entry;
  logic [$bits(verc_pkg::entry_t)-1:0] rd_bits;

  // exact site differences
  assign lx = {in_data.left_site_x[CW-1], in_data.left_site_x};
  assign ly = {in_data.left_site_y[CW-1], in_data.left_site_y};
  assign rx = {in_data.right_site_x[CW-1], in_data.right_site_x};
  assign ry = {in_data.right_site_y[CW-1], in_data.right_site_y};
  assign dx = lx - rx;
  assign dy = ly - ry;
  assign dx_neg_mag = DW'(rx - lx);
  assign dy_neg_mag = DW'(ry - ly);

  // classify
  always_comb begin
    entry.ctx.ib = in_data.first_end_infinite;
    entry.ctx.ie = in_data.second_end_infinite;
    entry.ctx.bx = in_data.first_end_x;
    entry.ctx.by = in_data.first_end_y;
    entry.ctx.ex = in_data.second_end_x;
    entry.ctx.ey = in_data.second_end_y;
    if (dy == '0) begin
      entry.ctx.status = verc_pkg::STATUS_HORIZONTAL;
    end else if (in_data.first_end_infinite && in_data.second_end_infinite) begin
      entry.ctx.status = verc_pkg::STATUS_BOTH_INF;
    end else begin
      entry.ctx.status = verc_pkg::STATUS_OK;
    end
    entry.dx_mag    = dx[CW] ? dx_neg_mag : DW'(dx);
    entry.dy_mag    = dy[CW] ? dy_neg_mag : DW'(dy);
    entry.slope_neg = (dx[CW] == dy[CW]);
  end

  verc_fifo #(
    .WIDTH ($bits(verc_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (entry),
    .full    (in_full),
    .pop     (head_pop),
    .rd_data (rd_bits),
    .empty   (head_empty)
  );

  assign head = verc_pkg::entry_t'(rd_bits);

endmodule

// File: hdl/verc_back.sv
// ----------------------------------------------------------------------------
// verc_back: line forming and border clipping
// Slope divider, intercept and right-border multipliers, border-crossing
// dividers and the final endpoint selection, all under one stall enable.
// ----------------------------------------------------------------------------
module verc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [verc_pkg::MAP_W-1:0] map_width,
  input  logic [verc_pkg::MAP_W-1:0] map_height,
  input  verc_pkg::entry_t           head,
  input  logic                       head_empty,
  output logic                       head_pop,
  output logic                       out_push,
  output verc_pkg::out_t             out_item,
  input  logic                       out_full
);

  localparam int CW = verc_pkg::COORD_W;
  localparam int DW = verc_pkg::DIV_W;
  localparam int PW = verc_pkg::PROD_W;
  localparam int FB = verc_pkg::FRAC_BITS;

  typedef struct packed {
    verc_pkg::ctx_t ctx;
    logic           sneg;
  } tag1_t;

  typedef struct packed {
    verc_pkg::ctx_t     ctx;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] ym;
    logic               xvalid;
    logic               xz_neg;
  } tag2_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pt_t;

  logic                 adv;
  logic signed [CW-1:0] w_s, h_s;
  logic [CW-1:0]        w_u;

  // slope divider
  logic          d1_v, d1_ovf;
  logic [DW-1:0] d1_q;
  tag1_t         d1_in_tag, d1_tag;
  logic [$bits(tag1_t)-1:0] d1_tag_bits;

  // multiplier section
  logic                 m0_v_r, m1_v_r, m2_v_r, m3_v_r, m4_v_r;
  verc_pkg::ctx_t       m0_ctx_r, m1_ctx_r, m2_ctx_r, m3_ctx_r, m4_ctx_r;
  logic [CW-1:0]        m0_smag_r, m1_smag_r, m2_smag_r, m3_smag_r, m4_smag_r;
  logic                 m0_sneg_r, m1_sneg_r, m2_sneg_r, m3_sneg_r, m4_sneg_r;
  logic [CW-1:0]        m0_fmag_r;
  logic                 m0_pneg_r, m1_pneg_r;
  logic [PW-1:0]        m1_pf_r, m1_pw_r;
  logic signed [CW-1:0] m2_mf_r, m2_mw_r, m3_mw_r;
  logic signed [CW-1:0] m3_c_r, m4_c_r, m4_ym_r;
  logic signed [CW:0]   m4_t_r;
  logic [CW-1:0]        smag1;
  logic signed [CW-1:0] fx1, fy3;
  logic                 slope_lt;

  // crossing dividers
  logic          d2_v, d2_ovf, d3_v, d3_ovf;
  logic [DW-1:0] d2_q, d3_q;
  tag2_t         d2_in_tag, d2_tag;
  logic [$bits(tag2_t)-1:0] d2_tag_bits;
  logic          d3_tag;

  // selection stage
  logic                 s0_v_r;
  verc_pkg::ctx_t       s0_ctx_r;
  logic signed [CW-1:0] s0_c_r, s0_ym_r, s0_xz_r, s0_xm_r;
  logic                 s0_xvalid_r;
  logic                 xz_in, xm_in, c_in, ym_in;

  assign w_u = CW'(map_width);
  assign w_s = $signed(CW'(map_width));
  assign h_s = $signed(CW'(map_height));

  // global stall when the final result cannot leave
  assign adv      = !(s0_v_r && out_full);
  assign head_pop = adv && !head_empty;
  assign out_push = s0_v_r && !out_full;

  assign d1_in_tag.ctx  = head.ctx;
  assign d1_in_tag.sneg = head.slope_neg;

  verc_div #(
    .TAG_W ($bits(tag1_t))
  ) u_slope_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (adv),
    .in_valid  (head_pop),
    .in_num    (head.dx_mag),
    .in_den    (head.dy_mag),
    .in_tag    (d1_in_tag),
    .out_valid (d1_v),
    .out_q     (d1_q),
    .out_ovf   (d1_ovf),
    .out_tag   (d1_tag_bits)
  );

  assign d1_tag = tag1_t'(d1_tag_bits);
  assign smag1  = verc_pkg::sat_mag(d1_tag.sneg, d1_ovf, PW'(d1_q));
  assign fx1    = d1_tag.ctx.ib ? d1_tag.ctx.ex : d1_tag.ctx.bx;
  assign fy3    = m2_ctx_r.ib ? m2_ctx_r.ey : m2_ctx_r.by;

  // slope, products, intercept and right-border crossing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_v_r <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
    end else if (adv) begin
      m0_v_r    <= d1_v;
      m0_ctx_r  <= d1_tag.ctx;
      m0_smag_r <= smag1;
      m0_sneg_r <= d1_tag.sneg;
      m0_fmag_r <= verc_pkg::abs_coord(fx1);
      m0_pneg_r <= d1_tag.sneg ^ fx1[CW-1];

      m1_v_r    <= m0_v_r;
      m1_ctx_r  <= m0_ctx_r;
      m1_smag_r <= m0_smag_r;
      m1_sneg_r <= m0_sneg_r;
      m1_pneg_r <= m0_pneg_r;
      m1_pf_r   <= m0_smag_r * m0_fmag_r;
      m1_pw_r   <= m0_smag_r * w_u;

      m2_v_r    <= m1_v_r;
      m2_ctx_r  <= m1_ctx_r;
      m2_smag_r <= m1_smag_r;
      m2_sneg_r <= m1_sneg_r;
      m2_mf_r   <= verc_pkg::sat_fit(m1_pneg_r, 1'b0, m1_pf_r >> FB);
      m2_mw_r   <= verc_pkg::sat_fit(m1_sneg_r, 1'b0, m1_pw_r >> FB);

      m3_v_r    <= m2_v_r;
      m3_ctx_r  <= m2_ctx_r;
      m3_smag_r <= m2_smag_r;
      m3_sneg_r <= m2_sneg_r;
      m3_mw_r   <= m2_mw_r;
      m3_c_r    <= verc_pkg::clamp_coord({fy3[CW-1], fy3} - {m2_mf_r[CW-1], m2_mf_r});

      m4_v_r    <= m3_v_r;
      m4_ctx_r  <= m3_ctx_r;
      m4_smag_r <= m3_smag_r;
      m4_sneg_r <= m3_sneg_r;
      m4_c_r    <= m3_c_r;
      m4_ym_r   <= verc_pkg::clamp_coord({m3_mw_r[CW-1], m3_mw_r} + {m3_c_r[CW-1], m3_c_r});
      m4_t_r    <= $signed({2'b00, map_height}) - {m3_c_r[CW-1], m3_c_r};
    end
  end

  // crossing divider operands
  assign slope_lt         = m4_sneg_r && (m4_smag_r != '0);
  assign d2_in_tag.ctx    = m4_ctx_r;
  assign d2_in_tag.c      = m4_c_r;
  assign d2_in_tag.ym     = m4_ym_r;
  assign d2_in_tag.xvalid = (m4_smag_r != '0);
  assign d2_in_tag.xz_neg = (m4_c_r[CW-1] == slope_lt);

  verc_div #(
    .TAG_W ($bits(tag2_t))
  ) u_xzero_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (adv),
    .in_valid  (m4_v_r),
    .in_num    (verc_pkg::abs_wide({m4_c_r[CW-1], m4_c_r})),
    .in_den    ({1'b0, m4_smag_r}),
    .in_tag    (d2_in_tag),
    .out_valid (d2_v),
    .out_q     (d2_q),
    .out_ovf   (d2_ovf),
    .out_tag   (d2_tag_bits)
  );

  verc_div #(
    .TAG_W (1)
  ) u_xmax_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (adv),
    .in_valid  (m4_v_r),
    .in_num    (verc_pkg::abs_wide(m4_t_r)),
    .in_den    ({1'b0, m4_smag_r}),
    .in_tag    (m4_t_r[CW] != slope_lt),
    .out_valid (d3_v),
    .out_q     (d3_q),
    .out_ovf   (d3_ovf),
    .out_tag   (d3_tag)
  );

  assign d2_tag = tag2_t'(d2_tag_bits);

  // crossings settled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r      <= d2_v && d3_v;
      s0_ctx_r    <= d2_tag.ctx;
      s0_c_r      <= d2_tag.c;
      s0_ym_r     <= d2_tag.ym;
      s0_xvalid_r <= d2_tag.xvalid;
      s0_xz_r     <= verc_pkg::sat_fit(d2_tag.xz_neg, d2_ovf, PW'(d2_q));
      s0_xm_r     <= verc_pkg::sat_fit(d3_tag, d3_ovf, PW'(d3_q));
    end
  end

  // border crossings that lie strictly inside the map sides
  assign xz_in = s0_xvalid_r && (s0_xz_r > 0) && (s0_xz_r < w_s);
  assign xm_in = s0_xvalid_r && (s0_xm_r > 0) && (s0_xm_r < w_s);
  assign c_in  = (s0_c_r > 0) && (s0_c_r < h_s);
  assign ym_in = (s0_ym_r > 0) && (s0_ym_r < h_s);

  function automatic logic is_inside(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y);
    return (x >= 0) && (x <= w_s) && (y >= 0) && (y <= h_s);
  endfunction

  // finite endpoint: later rules override earlier ones, clamp when none hits
  function automatic pt_t clip_finite(input logic signed [CW-1:0] x,
                                      input logic signed [CW-1:0] y);
    pt_t p;
    p.x = (x < 0) ? '0 : ((x > w_s) ? w_s : x);
    p.y = (y < 0) ? '0 : ((y > h_s) ? h_s : y);
    if (is_inside(x, y)) begin
      p.x = x;
      p.y = y;
    end else begin
      if (xz_in && (y < 0)) begin
        p.x = s0_xz_r;
        p.y = '0;
      end
      if (xm_in && (y > h_s)) begin
        p.x = s0_xm_r;
        p.y = h_s;
      end
      if (c_in && (x < 0)) begin
        p.x = '0;
        p.y = s0_c_r;
      end
      if (ym_in && (x > w_s)) begin
        p.x = w_s;
        p.y = s0_ym_r;
      end
    end
    return p;
  endfunction

  // infinite begin, other end at ox
  function automatic pt_t clip_inf_begin(input logic signed [CW-1:0] ox);
    pt_t p;
    if (s0_xvalid_r && (s0_xz_r > 0) && (s0_xz_r < ox)) begin
      p.x = s0_xz_r;
      p.y = '0;
    end else if (s0_xvalid_r && (s0_xm_r > 0) && (s0_xm_r < ox)) begin
      p.x = s0_xm_r;
      p.y = h_s;
    end else begin
      p.x = '0;
      p.y = s0_c_r;
    end
    return p;
  endfunction

  // infinite end, other end at ox
  function automatic pt_t clip_inf_end(input logic signed [CW-1:0] ox);
    pt_t p;
    if (s0_xvalid_r && (ox < s0_xm_r) && (s0_xm_r < w_s)) begin
      p.x = s0_xm_r;
      p.y = h_s;
    end else if (s0_xvalid_r && (ox < s0_xz_r) && (s0_xz_r < w_s)) begin
      p.x = s0_xz_r;
      p.y = '0;
    end else begin
      p.x = w_s;
      p.y = s0_ym_r;
    end
    return p;
  endfunction

  // result assembly
  always_comb begin
    pt_t p0, p1;
    logic cut0, cut1;
    p0   = '0;
    p1   = '0;
    cut0 = 1'b0;
    cut1 = 1'b0;
    if (!s0_ctx_r.ib) begin
      p0   = clip_finite(s0_ctx_r.bx, s0_ctx_r.by);
      cut0 = !is_inside(s0_ctx_r.bx, s0_ctx_r.by);
    end else begin
      p0   = clip_inf_begin(s0_ctx_r.ex);
      cut0 = 1'b1;
    end
    if (!s0_ctx_r.ie) begin
      p1   = clip_finite(s0_ctx_r.ex, s0_ctx_r.ey);
      cut1 = !is_inside(s0_ctx_r.ex, s0_ctx_r.ey);
    end else begin
      p1   = clip_inf_end(s0_ctx_r.bx);
      cut1 = 1'b1;
    end
    out_item        = '0;
    out_item.status = s0_ctx_r.status;
    if (s0_ctx_r.status == verc_pkg::STATUS_OK) begin
      out_item.clipped_first_x  = p0.x;
      out_item.clipped_first_y  = p0.y;
      out_item.clipped_second_x = p1.x;
      out_item.clipped_second_y = p1.y;
      out_item.first_was_cut    = cut0;
      out_item.second_was_cut   = cut1;
    end
  end

endmodule

// File: hdl/voronoi_edge_rect_clip.sv
// ----------------------------------------------------------------------------
// voronoi_edge_rect_clip: clips one Voronoi edge to the map rectangle per
// transaction. Edges pass the slope divider, then the two parallel crossing
// dividers; one transaction per cycle unless a full result queue stalls the back section.
// Synchronous active-low reset empties both queues and the pipeline and sets
// map width and height to 1024.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module voronoi_edge_rect_clip #(
  parameter int QUEUE_DEPTH = verc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  verc_pkg::in_t                  in_data,
  output logic                           out_empty,
  input  logic                           out_pop,
  output verc_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [verc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [verc_pkg::MAP_W-1:0]     cfg_wdata
);

  logic [verc_pkg::MAP_W-1:0] map_width_r, map_width_nxt;
  logic [verc_pkg::MAP_W-1:0] map_height_r, map_height_nxt;
  verc_pkg::entry_t           head;
  logic                       head_empty, head_pop;
  logic                       res_push, res_full;
  verc_pkg::out_t             res_item;
  logic [$bits(verc_pkg::out_t)-1:0] out_bits;

  // configuration registers
  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        verc_pkg::REG_MAP_WIDTH:  map_width_nxt  = cfg_wdata;
        verc_pkg::REG_MAP_HEIGHT: map_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= verc_pkg::MAP_SIZE_RESET;
      map_height_r <= verc_pkg::MAP_SIZE_RESET;
    end else begin
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
    end
  end

  verc_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop)
  );

  verc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .map_width  (map_width_r),
    .map_height (map_height_r),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .out_push   (res_push),
    .out_item   (res_item),
    .out_full   (res_full)
  );

  // result queue
  verc_fifo #(
    .WIDTH ($bits(verc_pkg::out_t)),
    .DEPTH (verc_pkg::OUT_Q_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_item),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_bits),
    .empty   (out_empty)
  );

  assign out_data = verc_pkg::out_t'(out_bits);

endmodule

// File: test/voronoi_edge_rect_clip_checker.sv
// ----------------------------------------------------------------------------
// voronoi_edge_rect_clip_checker: edge clipper scoreboard
// Watches the input, result and register ports, predicts every clipped edge
// and compares each popped result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module voronoi_edge_rect_clip_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_full,
  input  verc_pkg::in_t                  in_data,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  verc_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [verc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [verc_pkg::MAP_W-1:0]     cfg_wdata,
  output int                             error_count,
  output int                             pending_count
);
  import verc_pkg::*;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  longint map_w;
  longint map_h;
  out_t   clipped_q[$];

  // bisector line and its border crossings
  typedef struct {
    longint slope;
    longint c;
    longint xz;
    longint xm;
    longint ym;
    bit     xvalid;
  } line_s;

  function automatic logic [63:0] mag(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp32(input longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  // saturate a sign and a 128-bit magnitude into the coordinate range
  function automatic longint fit_coord(input bit neg, input logic [127:0] m);
    if (!neg) return m > 128'(CMAX) ? CMAX : longint'(m[63:0]);
    return m >= 128'(64'h8000_0000) ? CMIN : -longint'(m[63:0]);
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    logic [127:0] p;
    p = {64'b0, mag(a)} * {64'b0, mag(b)};
    return fit_coord((a < 0) != (b < 0), p >> FRAC_BITS);
  endfunction

  function automatic longint q_div(input bit neg, input logic [63:0] na,
                                   input logic [63:0] nb);
    logic [127:0] q;
    q = ({64'b0, na} << FRAC_BITS) / {64'b0, nb};
    return fit_coord(neg, q);
  endfunction

  // finite endpoint: pass through, or move to the border by ordered rules
  function automatic bit clip_finite(input line_s ln, input longint x, input longint y,
                                     output longint px, output longint py);
    bit hit;
    hit = 0;
    px = x;
    py = y;
    if (x >= 0 && x <= map_w && y >= 0 && y <= map_h) return 0;
    if (ln.xvalid && ln.xz > 0 && ln.xz < map_w && y < 0) begin
      px = ln.xz; py = 0; hit = 1;
    end
    if (ln.xvalid && ln.xm > 0 && ln.xm < map_w && y > map_h) begin
      px = ln.xm; py = map_h; hit = 1;
    end
    if (ln.c > 0 && ln.c < map_h && x < 0) begin
      px = 0; py = ln.c; hit = 1;
    end
    if (ln.ym > 0 && ln.ym < map_h && x > map_w) begin
      px = map_w; py = ln.ym; hit = 1;
    end
    if (!hit) begin
      px = x < 0 ? 0 : (x > map_w ? map_w : x);
      py = y < 0 ? 0 : (y > map_h ? map_h : y);
    end
    return 1;
  endfunction

  function automatic out_t clip_edge(input in_t d);
    out_t   r;
    line_s  ln;
    longint dx, dy, fx, fy, t;
    longint p0x, p0y, p1x, p1y;
    bit     cut0, cut1;
    r = '0;
    p0x = 0; p0y = 0; p1x = 0; p1y = 0;
    cut0 = 0; cut1 = 0;
    dx = longint'(d.left_site_x) - longint'(d.right_site_x);
    dy = longint'(d.left_site_y) - longint'(d.right_site_y);
    if (dy == 0) begin
      r.status = STATUS_HORIZONTAL;
      return r;
    end
    if (d.first_end_infinite && d.second_end_infinite) begin
      r.status = STATUS_BOTH_INF;
      return r;
    end
    ln.slope = q_div((dx < 0) == (dy < 0), mag(dx), mag(dy));
    fx = d.first_end_infinite ? longint'(d.second_end_x) : longint'(d.first_end_x);
    fy = d.first_end_infinite ? longint'(d.second_end_y) : longint'(d.first_end_y);
    ln.c = clamp32(fy - q_mul(ln.slope, fx));
    ln.xvalid = ln.slope != 0;
    ln.xz = 0;
    ln.xm = 0;
    if (ln.xvalid) begin
      ln.xz = q_div((ln.c < 0) == (ln.slope < 0), mag(ln.c), mag(ln.slope));
      t = map_h - ln.c;
      ln.xm = q_div((t < 0) != (ln.slope < 0), mag(t), mag(ln.slope));
    end
    ln.ym = clamp32(q_mul(ln.slope, map_w) + ln.c);

    if (!d.first_end_infinite) begin
      cut0 = clip_finite(ln, d.first_end_x, d.first_end_y, p0x, p0y);
      // infinite end: crossing to the right of the begin point
      if (d.second_end_infinite) begin
        cut1 = 1;
        if (ln.xvalid && d.first_end_x < ln.xm && ln.xm < map_w) begin
          p1x = ln.xm; p1y = map_h;
        end else if (ln.xvalid && d.first_end_x < ln.xz && ln.xz < map_w) begin
          p1x = ln.xz; p1y = 0;
        end else begin
          p1x = map_w; p1y = ln.ym;
        end
      end
    end
    if (!d.second_end_infinite) begin
      cut1 = clip_finite(ln, d.second_end_x, d.second_end_y, p1x, p1y);
      // infinite begin: crossing to the left of the end point
      if (d.first_end_infinite) begin
        cut0 = 1;
        if (ln.xvalid && ln.xz > 0 && ln.xz < d.second_end_x) begin
          p0x = ln.xz; p0y = 0;
        end else if (ln.xvalid && ln.xm > 0 && ln.xm < d.second_end_x) begin
          p0x = ln.xm; p0y = map_h;
        end else begin
          p0x = 0; p0y = ln.c;
        end
      end
    end
    r.clipped_first_x  = p0x[COORD_W-1:0];
    r.clipped_first_y  = p0y[COORD_W-1:0];
    r.clipped_second_x = p1x[COORD_W-1:0];
    r.clipped_second_y = p1y[COORD_W-1:0];
    r.first_was_cut    = cut0;
    r.second_was_cut   = cut1;
    r.status           = STATUS_OK;
    return r;
  endfunction

  assign pending_count = clipped_q.size();

  // register mirror, prediction on input transactions, compare on result ones
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      map_w = longint'(MAP_SIZE_RESET);
      map_h = longint'(MAP_SIZE_RESET);
      error_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_MAP_WIDTH) map_w = longint'(cfg_wdata);
        else if (cfg_idx == REG_MAP_HEIGHT) map_h = longint'(cfg_wdata);
      end
      if (in_push && !in_full) clipped_q = {clipped_q, clip_edge(in_data)};
      if (out_pop && !out_empty) begin
        if (clipped_q.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result transaction: %p", out_data);
        end else begin
          exp_r = clipped_q.pop_front();
          if (out_data !== exp_r) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: expected %p actual %p", exp_r, out_data);
          end
        end
      end
    end
  end

endmodule

// File: test/voronoi_edge_rect_clip_tb.sv
// ----------------------------------------------------------------------------
// voronoi_edge_rect_clip_tb: edge clipper testbench
// Drives directed and random Voronoi edges through several map sizes with
// random gaps on both queue sides and one long result stall; the checker
// predicts every clipped edge and counts mismatches.
// ----------------------------------------------------------------------------
module voronoi_edge_rect_clip_tb;
  import verc_pkg::*;

  localparam int ONE        = 65536;
  localparam int CYCLE_MAX  = 400000;
  localparam int DRAIN_WAIT = 150;

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_push = 0;
  logic                 in_full;
  in_t                  in_data = '0;
  logic                 out_empty;
  logic                 out_pop = 0;
  out_t                 out_data;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_MAP_WIDTH;
  logic [MAP_W-1:0]     cfg_wdata = '0;
  int                   error_count;
  int                   pending_count;
  int                   cycles = 0;
  int                   pops = 0;
  bit                   no_gaps = 0;
  longint               cur_w = 67108864;
  longint               cur_h = 67108864;
  longint               maps_w[6] = '{67108864, 1, 2147483647, 100 * ONE, 3 * ONE, 67108864};
  longint               maps_h[6] = '{67108864, 1, 2147483647, 40 * ONE, 500 * ONE, 2 * ONE};

  always #4 clk = ~clk;

  voronoi_edge_rect_clip uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  voronoi_edge_rect_clip_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .error_count(error_count), .pending_count(pending_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("voronoi_edge_rect_clip_tb NOT OK");
      $finish;
    end
  end

  // result side: random pop gaps, one long hold-off to fill the block
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      g = no_gaps ? 0 : $urandom_range(0, 12);
      if (pops == 200) g = 400;
      if (g > 0) begin
        out_pop = 0;
        repeat (g) @(negedge clk);
      end
      out_pop = 1;
      do @(posedge clk); while (out_empty);
      pops++;
    end
  end

  function automatic in_t mk_edge(int lx, int ly, int rx, int ry, int bx, int by,
                                  int ex, int ey, bit ib, bit ie);
    in_t d;
    d = '{lx, ly, rx, ry, bx, by, ex, ey, ib, ie};
    return d;
  endfunction

  // one input transaction, after a random gap
  task automatic send_edge(input in_t d);
    int g;
    g = no_gaps ? 0 : $urandom_range(0, 12);
    if (g > 0) begin
      in_push = 0;
      repeat (g) @(negedge clk);
    end
    in_push = 1;
    in_data = d;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  // coordinate near the current map, or anywhere
  function automatic int rand_coord(input longint lim);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return -int'($urandom_range(0, lim > ONE * 64 ? ONE * 64 : lim));
      2: return int'(lim + $urandom_range(0, ONE * 64));
      default: return int'($urandom_range(0, lim));
    endcase
  endfunction

  function automatic in_t rand_edge();
    in_t d;
    d.left_site_x  = rand_coord(cur_w);
    d.left_site_y  = rand_coord(cur_h);
    d.right_site_x = rand_coord(cur_w);
    d.right_site_y = ($urandom_range(0, 19) == 0) ? d.left_site_y : rand_coord(cur_h);
    if ($urandom_range(0, 19) == 0) d.right_site_x = d.left_site_x;
    d.first_end_x  = rand_coord(cur_w);
    d.first_end_y  = rand_coord(cur_h);
    d.second_end_x = rand_coord(cur_w);
    d.second_end_y = rand_coord(cur_h);
    d.first_end_infinite  = $urandom_range(0, 3) == 0;
    d.second_end_infinite = $urandom_range(0, 3) == 0;
    return d;
  endfunction

  // wait until every result is in, then let the pipeline settle
  task automatic drain();
    in_push = 0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_map(input longint w, input longint h);
    cfg_we = 1;
    cfg_idx = REG_MAP_WIDTH;
    cfg_wdata = MAP_W'(w);
    @(negedge clk);
    cfg_idx = REG_MAP_HEIGHT;
    cfg_wdata = MAP_W'(h);
    @(negedge clk);
    cfg_we = 0;
    cur_w = w;
    cur_h = h;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1;

    // directed edges on the reset map
    set_map(67108864, 67108864);
    send_edge(mk_edge(0, 0, 0, 0, 5, 5, 6, 6, 0, 0));
    send_edge(mk_edge(0, 0, ONE, ONE, 5, 5, 6, 6, 1, 1));
    send_edge(mk_edge(0, 0, ONE, ONE, 10 * ONE, 10 * ONE, 20 * ONE, 20 * ONE, 0, 0));
    send_edge(mk_edge(0, 0, 0, ONE, 10 * ONE, 20 * ONE, 900 * ONE, 20 * ONE, 0, 0));
    send_edge(mk_edge(0, 0, 0, ONE, -ONE, 20 * ONE, 2000 * ONE, 20 * ONE, 0, 0));
    send_edge(mk_edge(0, 0, 0, ONE, 0, 20 * ONE, 0, 0, 1, 0));
    send_edge(mk_edge(0, 0, 0, ONE, 50 * ONE, 20 * ONE, 0, 0, 0, 1));
    send_edge(mk_edge(0, 0, ONE, ONE, 10 * ONE, 10 * ONE, 20 * ONE, 20 * ONE, 1, 0));
    send_edge(mk_edge(0, 0, ONE, ONE, 10 * ONE, 10 * ONE, 20 * ONE, 20 * ONE, 0, 1));
    send_edge(mk_edge(ONE, 0, 0, ONE, 10 * ONE, -5 * ONE, 20 * ONE, 1100 * ONE, 0, 0));
    send_edge(mk_edge(ONE, 0, 0, ONE, -5 * ONE, 10 * ONE, 1100 * ONE, 20 * ONE, 0, 0));
    send_edge(mk_edge(0, 0, ONE, ONE, -5 * ONE, -5 * ONE, 2000 * ONE, 2000 * ONE, 0, 0));
    send_edge(mk_edge(0, 0, 3 * ONE, ONE, -5 * ONE, 3000 * ONE, 3000 * ONE, -9 * ONE, 0, 0));
    send_edge(mk_edge(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0));
    send_edge(mk_edge(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 1));
    send_edge(mk_edge(32'h80000000, 0, 32'h7fffffff, 1, 0, 0, 67108864, 67108864, 1, 0));
    send_edge(mk_edge(1, 0, 0, 32'h7fffffff, 67108864, 0, 0, 67108864, 0, 0));
    send_edge(mk_edge(-1, -1, -1, -1, -1, -1, -1, -1, 1, 1));
    send_edge(mk_edge(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // random edges over a sequence of map sizes
    for (int ph = 0; ph < 6; ph++) begin
      set_map(maps_w[ph], maps_h[ph]);
      for (int i = 0; i < 260; i++) begin
        if (i % 64 == 0) no_gaps = $urandom_range(0, 2) == 0;
        send_edge(rand_edge());
      end
      no_gaps = 0;
      drain();
    end

    if (error_count == 0 && pending_count == 0) begin
      $display("voronoi_edge_rect_clip_tb OK");
    end else begin
      $display("voronoi_edge_rect_clip_tb NOT OK");
    end
    $finish;
  end
endmodule
